>>> src/smcs_pkg.sv
`timescale 1ns / 1ps

package smcs_pkg;

    // SDO command specifiers and object indexes
    localparam logic [7:0]  SDO_CCS_WRITE4 = 8'h23;
    localparam logic [7:0]  SDO_SCS_ABORT  = 8'h80;
    localparam logic [7:0]  SDO_SCS_ACK    = 8'h60;
    localparam logic [7:0]  IDX_MAP_CLEAR  = 8'h31;
    localparam logic [7:0]  IDX_MAP_ROW    = 8'h30;
    localparam logic [7:0]  IDX_SAVE       = 8'h50;
    localparam logic [7:0]  SUB_TX_MAP     = 8'h00;
    localparam logic [7:0]  SUB_RX_MAP     = 8'h80;
    localparam logic [7:0]  SUB_SAVE_FLASH = 8'h02;
    localparam logic [10:0] REQ_BASE       = 11'h600;
    localparam logic [10:0] RSP_BASE       = 11'h580;

    localparam int NODE_W = 7;
    localparam int ROW_W  = 3;
    localparam int RUN_W  = 3;

    localparam logic [NODE_W-1:0] NODE_RESET = 7'd1;

    typedef logic [10:0][7:0] map_row_t;

    typedef struct packed {
        logic       cmd;
        logic [10:0] frame_id;
        logic [7:0] resp_first_byte;
    } item_t;

    typedef struct packed {
        logic        kind;
        logic [10:0] tx_id;
        logic [63:0] tx_data;
    } result_t;

    // Fixed mapping table; byte 0 sits at index 0. Rows past the table read as zero.
    function automatic map_row_t map_rom(input logic [ROW_W-1:0] row);
        map_row_t r;
        r = '0;
        case (row)
            3'd0: r = {8'h00, 8'h03, 8'hE8, 8'h08, 8'h00, 8'h07, 8'hD0,
                       8'h00, 8'h00, 8'h01, 8'h90};
            3'd1: r = {8'h00, 8'h27, 8'h10, 8'h10, 8'h08, 8'h07, 8'hD1,
                       8'h00, 8'h00, 8'h01, 8'h90};
            3'd2: r = {8'h00, 8'h03, 8'hE8, 8'h10, 8'h18, 8'h07, 8'hDC,
                       8'h00, 8'h00, 8'h01, 8'h90};
            3'd3: r = {8'h1E, 8'h03, 8'hE8, 8'h08, 8'h28, 8'h07, 8'hE3,
                       8'h00, 8'h00, 8'h01, 8'h90};
            3'd4: r = {8'h1E, 8'h03, 8'hE8, 8'h08, 8'h30, 8'h07, 8'hE4,
                       8'h00, 8'h00, 8'h01, 8'h90};
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

>>> src/smcs_if.sv
`timescale 1ns / 1ps

interface smcs_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [10:0] frame_id;
    logic [7:0]  resp_first_byte;

    modport source (output valid, output cmd, output frame_id, output resp_first_byte,
                    input ready);
    modport sink (input valid, input cmd, input frame_id, input resp_first_byte,
                  output ready);
endinterface

interface smcs_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [10:0] tx_id;
    logic [63:0] tx_data;

    modport source (output valid, output kind, output tx_id, output tx_data,
                    input ready);
    modport sink (input valid, input kind, input tx_id, input tx_data,
                  output ready);
endinterface

>>> src/smcs_in_stage.sv
`timescale 1ns / 1ps

module smcs_in_stage (
    input  logic           clk,
    input  logic           rst_n,
    smcs_in_if.sink        item,
    input  logic           take,
    output logic           held_valid,
    output smcs_pkg::item_t held
);
    import smcs_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    // accept when empty or when the held word leaves this cycle
    assign item.ready = !valid_reg || take;
    assign held_valid = valid_reg;
    assign held       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.ready && item.valid)
        begin
            item_reg <= '{cmd: item.cmd, frame_id: item.frame_id,
                          resp_first_byte: item.resp_first_byte};
        end
    end

endmodule

>>> src/smcs_seq.sv
`timescale 1ns / 1ps

module smcs_seq #(
    parameter int MAP_ROWS    = 5,
    parameter int ABORT_LIMIT = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [smcs_pkg::NODE_W-1:0]   node_id,
    input  logic                          fire,
    input  smcs_pkg::item_t               cur,
    output logic                          res_valid,
    output smcs_pkg::result_t             res
);
    import smcs_pkg::*;

    typedef enum logic [2:0] {
        PH_CLEAR_TX = 3'd0,
        PH_CLEAR_RX = 3'd1,
        PH_MAP      = 3'd2,
        PH_SKIP_RX  = 3'd3,
        PH_SAVE     = 3'd4,
        PH_DONE     = 3'd5
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [1:0]       sub_reg, sub_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             await_reg, await_next;
    logic             abort_reg, abort_next;
    logic             ack_reg, ack_next;
    logic [RUN_W-1:0] run_reg, run_next;

    logic [10:0] req_id;
    logic [10:0] rsp_id;
    map_row_t    rom_row;
    logic        emit;
    logic [63:0] emit_data;

    assign req_id  = REQ_BASE + {4'd0, node_id};
    assign rsp_id  = RSP_BASE + {4'd0, node_id};
    assign rom_row = map_rom(row_reg);

    always_comb
    begin
        phase_next = phase_reg;
        sub_next   = sub_reg;
        row_next   = row_reg;
        await_next = await_reg;
        abort_next = abort_reg;
        ack_next   = ack_reg;
        run_next   = run_reg;
        emit       = 1'b0;
        emit_data  = '0;
        res_valid  = 1'b0;
        res        = '0;

        if (cur.cmd)
        begin
            if (cur.frame_id == rsp_id && await_reg)
            begin
                if (cur.resp_first_byte == SDO_SCS_ABORT)
                begin
                    abort_next = 1'b1;
                    if (run_reg != {RUN_W{1'b1}})
                    begin
                        run_next = run_reg + 1'b1;
                    end
                end
                else
                begin
                    if (cur.resp_first_byte == SDO_SCS_ACK)
                    begin
                        ack_next = 1'b1;
                    end
                    run_next = '0;
                end
                await_next = 1'b0;
                if (run_next > RUN_W'(ABORT_LIMIT))
                begin
                    phase_next = PH_DONE;
                end
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_CLEAR_TX, PH_CLEAR_RX:
                begin
                    if (!await_reg && !abort_reg)
                    begin
                        emit      = 1'b1;
                        emit_data = {40'd0, IDX_MAP_CLEAR,
                                     (phase_reg == PH_CLEAR_TX) ? SUB_TX_MAP : SUB_RX_MAP,
                                     SDO_CCS_WRITE4};
                    end
                    else if (abort_reg)
                    begin
                        abort_next = 1'b0;
                        if (phase_reg == PH_CLEAR_RX)
                        begin
                            sub_next   = 2'd0;
                            ack_next   = 1'b0;
                            phase_next = PH_MAP;
                        end
                        else
                        begin
                            phase_next = PH_CLEAR_RX;
                        end
                    end
                end
                PH_MAP:
                begin
                    if (row_reg >= ROW_W'(MAP_ROWS))
                    begin
                        await_next = 1'b0;
                        sub_next   = 2'd0;
                        row_next   = '0;
                        phase_next = PH_SKIP_RX;
                    end
                    else
                    begin
                        // cascade through the three writes of a row
                        if (sub_next == 2'd0)
                        begin
                            if (ack_next)
                            begin
                                sub_next = 2'd1;
                                ack_next = 1'b0;
                            end
                            else if (!await_reg)
                            begin
                                emit      = 1'b1;
                                emit_data = {rom_row[3], rom_row[2], rom_row[1], rom_row[0],
                                             8'h00, IDX_MAP_ROW, 8'h00, SDO_CCS_WRITE4};
                            end
                        end
                        if (!emit && sub_next == 2'd1)
                        begin
                            if (ack_next)
                            begin
                                sub_next = 2'd2;
                                ack_next = 1'b0;
                            end
                            else if (!await_reg)
                            begin
                                emit      = 1'b1;
                                emit_data = {rom_row[7], rom_row[6], rom_row[5], rom_row[4],
                                             8'h01, IDX_MAP_ROW, 8'h00, SDO_CCS_WRITE4};
                            end
                        end
                        if (!emit && sub_next == 2'd2)
                        begin
                            if (ack_next)
                            begin
                                sub_next = 2'd0;
                                ack_next = 1'b0;
                                row_next = row_reg + 1'b1;
                            end
                            else if (!await_reg)
                            begin
                                emit      = 1'b1;
                                emit_data = {rom_row[10], 8'h00, rom_row[9], rom_row[8],
                                             8'h02, IDX_MAP_ROW, 8'h00, SDO_CCS_WRITE4};
                            end
                        end
                    end
                end
                PH_SKIP_RX:
                begin
                    await_next = 1'b0;
                    sub_next   = 2'd0;
                    row_next   = '0;
                    ack_next   = 1'b0;
                    phase_next = PH_SAVE;
                end
                PH_SAVE:
                begin
                    if (!await_reg && !ack_reg)
                    begin
                        emit      = 1'b1;
                        emit_data = {40'd0, IDX_SAVE, SUB_SAVE_FLASH, SDO_CCS_WRITE4};
                    end
                    else if (ack_reg)
                    begin
                        phase_next = PH_DONE;
                    end
                end
                default:
                begin
                    res_valid = 1'b1;
                    res.kind  = 1'b1;
                end
            endcase

            if (emit)
            begin
                await_next  = 1'b1;
                res_valid   = 1'b1;
                res.kind    = 1'b0;
                res.tx_id   = req_id;
                res.tx_data = emit_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_CLEAR_TX;
            sub_reg   <= 2'd0;
            row_reg   <= '0;
            await_reg <= 1'b0;
            abort_reg <= 1'b0;
            ack_reg   <= 1'b0;
            run_reg   <= '0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            sub_reg   <= sub_next;
            row_reg   <= row_next;
            await_reg <= await_next;
            abort_reg <= abort_next;
            ack_reg   <= ack_next;
            run_reg   <= run_next;
        end
    end

endmodule

>>> src/smcs_out_stage.sv
`timescale 1ns / 1ps

module smcs_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  smcs_pkg::result_t res,
    output logic              space,
    smcs_out_if.source        result
);
    import smcs_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    // room when empty or when the waiting word is taken this cycle
    assign space          = !valid_reg || result.ready;
    assign result.valid   = valid_reg;
    assign result.kind    = res_reg.kind;
    assign result.tx_id   = res_reg.tx_id;
    assign result.tx_data = res_reg.tx_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (space)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

endmodule

>>> src/sdo_mapping_config_sequencer.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake     Word
// item      in   valid/ready   cmd, frame_id[10:0], resp_first_byte[7:0]
// result    out  valid/ready   kind, tx_id[10:0], tx_data[63:0]
// cfg       in   cfg_we        cfg_wdata[6:0] = node_id
//
// One word per cycle sustained while the result is not stalled; a word passes
// through the input register, then through the next-state logic into the
// result register. Reset clears the sequencer state and sets node_id to 1.
// A stalled result holds the result register; the input register keeps
// accepting while it has room, then drops ready until the result is taken.

module sdo_mapping_config_sequencer #(
    parameter int MAP_ROWS    = 5,
    parameter int ABORT_LIMIT = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [smcs_pkg::NODE_W-1:0] cfg_wdata,
    smcs_in_if.sink                     item,
    smcs_out_if.source                  result
);
    import smcs_pkg::*;

    logic [NODE_W-1:0] node_reg;
    logic              held_valid;
    item_t             held;
    logic              space;
    logic              fire;
    logic              res_valid;
    result_t           res;

    // advance the held word only when the result register can take its output
    assign fire = held_valid && space;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_reg <= NODE_RESET;
        end
        else if (cfg_we)
        begin
            node_reg <= cfg_wdata;
        end
    end

    smcs_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .take       (fire),
        .held_valid (held_valid),
        .held       (held)
    );

    smcs_seq #(
        .MAP_ROWS    (MAP_ROWS),
        .ABORT_LIMIT (ABORT_LIMIT)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .node_id   (node_reg),
        .fire      (fire),
        .cur       (held),
        .res_valid (res_valid),
        .res       (res)
    );

    smcs_out_stage u_out (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (fire && res_valid),
        .res    (res),
        .space  (space),
        .result (result)
    );

endmodule

>>> src/smcs_checker.sv
`timescale 1ns / 1ps

module smcs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        out_kind,
    input logic [10:0] out_tx_id,
    input logic [63:0] out_tx_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_kind) && $stable(out_tx_id)
                                    && $stable(out_tx_data))
        else $error("stalled result word changed");

    a_done_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind |-> out_tx_id == 11'd0 && out_tx_data == 64'd0)
        else $error("completion word carries frame payload");

    a_req_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_kind |-> out_tx_id[10:7] == 4'hC && out_tx_data[7:0] == 8'h23)
        else $error("request word is not a download to the request id range");

endmodule

bind sdo_mapping_config_sequencer smcs_checker u_smcs_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .out_kind    (result.kind),
    .out_tx_id   (result.tx_id),
    .out_tx_data (result.tx_data)
);
